>>> sv/motor_feedback_multiturn_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-turn feedback decoder
// Concurrent checks clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef MOTOR_FEEDBACK_MULTITURN_DECODER_TOP_MACROS_SVH
`define MOTOR_FEEDBACK_MULTITURN_DECODER_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define MFMD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
// Antecedent implies consequent a fixed number of cycles later.
`define MFMD_ASSERT_LAT(lbl, ante, n, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##n (cons)) \
    else $error(msg);
`else
`define MFMD_ASSERT_IMPL(lbl, ante, cons, msg)
`define MFMD_ASSERT_LAT(lbl, ante, n, cons, msg)
`endif
`endif

>>> sv/mfmd_pkg.sv
// ----------------------------------------------------------------------------
// mfmd_pkg
// Shared types and constants of the multi-turn feedback decoder.
// ----------------------------------------------------------------------------
package mfmd_pkg;

  localparam int unsigned IdW     = 11;
  localparam int unsigned EncW    = 16;
  localparam int unsigned TurnW   = 32;
  localparam int unsigned FiltW   = 24;
  localparam int unsigned AngW    = 48;
  localparam int unsigned AlphaW  = 16;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned MaxIdxW = 4;

  localparam logic [IdW-1:0] IdFirst = 11'h201;
  localparam logic [IdW-1:0] IdLast  = 11'h208;

  localparam logic [AlphaW:0]    AlphaOne   = 17'h10000;
  localparam logic [AlphaW-1:0]  AlphaReset = 16'd58982;
  localparam logic [TurnW-1:0]   TurnMax    = 32'h7FFF_FFFF;
  localparam logic [TurnW-1:0]   TurnMin    = 32'h8000_0000;

  // Configuration register indexes.
  localparam logic [1:0] RegPresent = 2'd0;
  localparam logic [1:0] RegReverse = 2'd1;
  localparam logic [1:0] RegAlpha   = 2'd2;

  localparam int unsigned FifoDepth = 8;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth) + 1;

  typedef enum logic [2:0] {
    AdjNone,
    AdjInc,
    AdjDec,
    AdjIncWrap,
    AdjDecWrap
  } turn_adj_e;

  // One entry of the per-motor state memory.
  typedef struct packed {
    logic [EncW-1:0]  prev_enc;
    logic [TurnW-1:0] turns;
    logic [FiltW-1:0] speed;
    logic [FiltW-1:0] current;
    logic [AngW-1:0]  angle;
  } entry_t;

  // Decoded frame entering the update pipeline.
  typedef struct packed {
    logic             bus;
    logic [SlotW-1:0] slot;
    logic [EncW-1:0]  enc;
    logic [FiltW-1:0] xs;
    logic [FiltW-1:0] xc;
  } item_t;

  typedef struct packed {
    logic             bus;
    logic [SlotW-1:0] slot;
    logic [EncW-1:0]  enc;
    logic [TurnW-1:0] turns;
    logic [FiltW-1:0] speed;
    logic [FiltW-1:0] current;
    logic [AngW-1:0]  angle;
  } result_t;

  typedef struct packed {
    logic               vld;
    logic [MaxIdxW-1:0] idx;
  } stage_stat_t;

  typedef struct packed {
    stage_stat_t a;
    stage_stat_t b;
    stage_stat_t c;
    stage_stat_t d;
  } pipe_stat_t;

endpackage

>>> sv/mfmd_state_mem.sv
// ----------------------------------------------------------------------------
// mfmd_state_mem
// Per-motor state memory with registered read, write-first bypass and valid
// bits so that entries never written read as zero.
// ----------------------------------------------------------------------------
module mfmd_state_mem import mfmd_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_idx_i,
  output entry_t                                rd_ent_o,
  input  logic                                  wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_idx_i,
  input  entry_t                                wr_ent_i
);

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t           mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q;
  entry_t           rd_q;
  logic             rd_vld_q;
  logic             bypass;

  assign bypass = wr_en_i && (wr_idx_i == rd_idx_i);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_ent_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (bypass) begin
        rd_q <= wr_ent_i;
      end else begin
        rd_q <= mem_q[rd_idx_i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= bypass || valid_q[rd_idx_i];
      end
    end
  end

  assign rd_ent_o = rd_vld_q ? rd_q : '0;

endmodule

>>> sv/mfmd_pipe.sv
// ----------------------------------------------------------------------------
// mfmd_pipe
// Four-stage update: turn detection, Q.8 low-pass filters and write-back of
// the new motor state.
// ----------------------------------------------------------------------------
module mfmd_pipe import mfmd_pkg::*; #(
  parameter int unsigned COUNTS_PER_TURN = 8192
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_vld_i,
  input  logic [MaxIdxW-1:0] in_idx_i,
  input  item_t              in_item_i,
  input  logic [AlphaW-1:0]  alpha_i,
  input  entry_t             ent_i,
  output pipe_stat_t         stat_o,
  output logic               wr_en_o,
  output logic [MaxIdxW-1:0] wr_idx_o,
  output entry_t             wr_ent_o,
  output result_t            res_o
);

  localparam logic signed [17:0] CptS     = 18'(COUNTS_PER_TURN);
  localparam logic signed [17:0] HalfTurn = 18'(COUNTS_PER_TURN / 2);
  localparam logic signed [50:0] CptL     = 51'(COUNTS_PER_TURN);
  localparam logic signed [50:0] CptHi    = CptL <<< 32;
  localparam logic signed [50:0] XMax     = (51'sd1 <<< 39) - 51'sd1;
  localparam logic signed [50:0] XMin     = -(51'sd1 <<< 39);
  localparam logic signed [41:0] Round42  = 42'sd32768;
  localparam logic signed [65:0] Round66  = 66'sd32768;

  logic [AlphaW:0]   beta;
  logic signed [17:0] alpha_s;
  logic signed [17:0] beta_s;

  assign beta    = AlphaOne - {1'b0, alpha_i};
  assign alpha_s = $signed({2'b00, alpha_i});
  assign beta_s  = $signed({1'b0, beta});

  // Stage A: item plus the state entry read at acceptance.
  logic               a_vld_q;
  logic [MaxIdxW-1:0] a_idx_q;
  item_t              a_item_q;

  logic signed [17:0] diff_a;
  logic               inc_a;
  logic               dec_a;
  turn_adj_e          adj_a;
  logic [TurnW-1:0]   turns_a;
  logic signed [49:0] prod_a;
  logic signed [41:0] psy_a;
  logic signed [41:0] psx_a;
  logic signed [41:0] pcy_a;
  logic signed [41:0] pcx_a;

  assign diff_a = 18'($signed(a_item_q.enc)) - 18'($signed(ent_i.prev_enc));
  assign inc_a  = diff_a < -HalfTurn;
  assign dec_a  = diff_a > HalfTurn;

  always_comb begin
    adj_a   = AdjNone;
    turns_a = ent_i.turns;
    if (dec_a) begin
      adj_a   = (ent_i.turns == TurnMin) ? AdjDecWrap : AdjDec;
      turns_a = ent_i.turns - 32'd1;
    end else if (inc_a) begin
      adj_a   = (ent_i.turns == TurnMax) ? AdjIncWrap : AdjInc;
      turns_a = ent_i.turns + 32'd1;
    end
  end

  // The product uses the old count; stage B adds the turn adjustment.
  assign prod_a = $signed(ent_i.turns) * CptS;
  assign psy_a  = $signed(ent_i.speed) * alpha_s;
  assign psx_a  = $signed(a_item_q.xs) * beta_s;
  assign pcy_a  = $signed(ent_i.current) * alpha_s;
  assign pcx_a  = $signed(a_item_q.xc) * beta_s;

  // Stage B
  logic               b_vld_q;
  logic [MaxIdxW-1:0] b_idx_q;
  logic               b_bus_q;
  logic [SlotW-1:0]   b_slot_q;
  logic [EncW-1:0]    b_enc_q;
  logic [TurnW-1:0]   b_turns_q;
  turn_adj_e          b_adj_q;
  logic signed [49:0] b_prod_q;
  logic signed [41:0] b_psy_q;
  logic signed [41:0] b_psx_q;
  logic signed [41:0] b_pcy_q;
  logic signed [41:0] b_pcx_q;
  logic [AngW-1:0]    b_ya_q;

  logic signed [50:0] adj_term;
  logic signed [50:0] xr_b;
  logic [AngW-1:0]    xa_b;
  logic signed [41:0] ssum_b;
  logic signed [41:0] csum_b;

  always_comb begin
    case (b_adj_q)
      AdjInc:     adj_term = CptL;
      AdjDec:     adj_term = -CptL;
      AdjIncWrap: adj_term = CptL - CptHi;
      AdjDecWrap: adj_term = CptHi - CptL;
      default:    adj_term = '0;
    endcase
  end

  assign xr_b = 51'(b_prod_q) + adj_term + 51'($signed(b_enc_q));

  always_comb begin
    if (xr_b > XMax) begin
      xa_b = {1'b0, {(AngW-1){1'b1}}};
    end else if (xr_b < XMin) begin
      xa_b = {1'b1, {(AngW-1){1'b0}}};
    end else begin
      xa_b = {xr_b[39:0], 8'h00};
    end
  end

  assign ssum_b = b_psy_q + b_psx_q + Round42;
  assign csum_b = b_pcy_q + b_pcx_q + Round42;

  // Stage C
  logic               c_vld_q;
  logic [MaxIdxW-1:0] c_idx_q;
  logic               c_bus_q;
  logic [SlotW-1:0]   c_slot_q;
  logic [EncW-1:0]    c_enc_q;
  logic [TurnW-1:0]   c_turns_q;
  logic [FiltW-1:0]   c_speed_q;
  logic [FiltW-1:0]   c_cur_q;
  logic [AngW-1:0]    c_xa_q;
  logic [AngW-1:0]    c_ya_q;

  // The 48-bit angle terms are split into a signed upper and unsigned lower half.
  logic signed [41:0] pyh_c;
  logic signed [42:0] pyl_c;
  logic signed [41:0] pxh_c;
  logic signed [42:0] pxl_c;

  assign pyh_c = $signed(c_ya_q[47:24]) * alpha_s;
  assign pyl_c = $signed({1'b0, c_ya_q[23:0]}) * alpha_s;
  assign pxh_c = $signed(c_xa_q[47:24]) * beta_s;
  assign pxl_c = $signed({1'b0, c_xa_q[23:0]}) * beta_s;

  // Stage D
  logic               d_vld_q;
  logic [MaxIdxW-1:0] d_idx_q;
  logic               d_bus_q;
  logic [SlotW-1:0]   d_slot_q;
  logic [EncW-1:0]    d_enc_q;
  logic [TurnW-1:0]   d_turns_q;
  logic [FiltW-1:0]   d_speed_q;
  logic [FiltW-1:0]   d_cur_q;
  logic signed [41:0] d_pyh_q;
  logic signed [42:0] d_pyl_q;
  logic signed [41:0] d_pxh_q;
  logic signed [42:0] d_pxl_q;

  logic signed [65:0] hsum_d;
  logic signed [65:0] tot_d;
  logic [AngW-1:0]    angle_d;

  assign hsum_d  = 66'(d_pyh_q) + 66'(d_pxh_q);
  assign tot_d   = (hsum_d <<< 24) + 66'(d_pyl_q) + 66'(d_pxl_q) + Round66;
  assign angle_d = tot_d[63:16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
      c_vld_q <= 1'b0;
      d_vld_q <= 1'b0;
    end else begin
      a_vld_q <= in_vld_i;
      b_vld_q <= a_vld_q;
      c_vld_q <= b_vld_q;
      d_vld_q <= c_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_idx_q  <= in_idx_i;
    a_item_q <= in_item_i;

    b_idx_q   <= a_idx_q;
    b_bus_q   <= a_item_q.bus;
    b_slot_q  <= a_item_q.slot;
    b_enc_q   <= a_item_q.enc;
    b_turns_q <= turns_a;
    b_adj_q   <= adj_a;
    b_prod_q  <= prod_a;
    b_psy_q   <= psy_a;
    b_psx_q   <= psx_a;
    b_pcy_q   <= pcy_a;
    b_pcx_q   <= pcx_a;
    b_ya_q    <= ent_i.angle;

    c_idx_q   <= b_idx_q;
    c_bus_q   <= b_bus_q;
    c_slot_q  <= b_slot_q;
    c_enc_q   <= b_enc_q;
    c_turns_q <= b_turns_q;
    c_speed_q <= ssum_b[39:16];
    c_cur_q   <= csum_b[39:16];
    c_xa_q    <= xa_b;
    c_ya_q    <= b_ya_q;

    d_idx_q   <= c_idx_q;
    d_bus_q   <= c_bus_q;
    d_slot_q  <= c_slot_q;
    d_enc_q   <= c_enc_q;
    d_turns_q <= c_turns_q;
    d_speed_q <= c_speed_q;
    d_cur_q   <= c_cur_q;
    d_pyh_q   <= pyh_c;
    d_pyl_q   <= pyl_c;
    d_pxh_q   <= pxh_c;
    d_pxl_q   <= pxl_c;
  end

  assign stat_o.a = '{vld: a_vld_q, idx: a_idx_q};
  assign stat_o.b = '{vld: b_vld_q, idx: b_idx_q};
  assign stat_o.c = '{vld: c_vld_q, idx: c_idx_q};
  assign stat_o.d = '{vld: d_vld_q, idx: d_idx_q};

  assign wr_en_o  = d_vld_q;
  assign wr_idx_o = d_idx_q;
  assign wr_ent_o = '{prev_enc: d_enc_q, turns: d_turns_q, speed: d_speed_q,
                      current: d_cur_q, angle: angle_d};
  assign res_o    = '{bus: d_bus_q, slot: d_slot_q, enc: d_enc_q, turns: d_turns_q,
                      speed: d_speed_q, current: d_cur_q, angle: angle_d};

endmodule

>>> sv/mfmd_out_fifo.sv
// ----------------------------------------------------------------------------
// mfmd_out_fifo
// Result queue with slot reservation, so that the update pipeline never has
// to stall once a frame is taken.
// ----------------------------------------------------------------------------
module mfmd_out_fifo import mfmd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    reserve_i,
  output logic    space_o,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    out_vld_o,
  input  logic    out_rdy_i,
  output result_t out_data_o
);

  result_t             mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q;
  logic [FifoPtrW-1:0] rd_ptr_q;
  // Counts stored results plus frames still in the pipeline.
  logic [FifoPtrW-1:0] cnt_q;
  logic [FifoPtrW-1:0] cnt_d;
  logic                pop;

  assign out_vld_o  = wr_ptr_q != rd_ptr_q;
  assign pop        = out_vld_o && out_rdy_i;
  assign space_o    = cnt_q < FifoPtrW'(FifoDepth);
  assign out_data_o = mem_q[rd_ptr_q[FifoPtrW-2:0]];
  assign cnt_d      = cnt_q + FifoPtrW'(reserve_i) - FifoPtrW'(pop);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q[FifoPtrW-2:0]] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

endmodule

>>> sv/motor_feedback_multiturn_decoder_top.sv
// ----------------------------------------------------------------------------
// motor_feedback_multiturn_decoder_top
// Decodes motor feedback frames, tracks whole turns and low-pass filters
// speed, current and multi-turn angle per motor.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake            Contents
// in        input      in_valid/in_ready    one feedback frame
// out       output     out_valid/out_ready  updated state of one motor
// cfg       input      cfg_we               present mask, reverse mask, alpha
//
// A present motor's frame yields one result. Frames for different motors are
// taken every cycle while the queue has space; one for the same motor waits
// while an earlier one is in stages A to C, for the read-modify-write loop
// through the state memory. Dropped frames never stall and give no result. An
// eight-entry result queue absorbs output stalls; input stalls when it is fully
// reserved. After reset the state reads as zero through valid bits.
// ----------------------------------------------------------------------------
`include "motor_feedback_multiturn_decoder_top_macros.svh"

module motor_feedback_multiturn_decoder_top import mfmd_pkg::*; #(
  parameter int unsigned NUM_BUSES       = 2,
  parameter int unsigned MOTORS_PER_BUS  = 8,
  parameter int unsigned COUNTS_PER_TURN = 8192
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [1:0]               cfg_idx_i,
  input  logic [AlphaW-1:0]        cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     bus_index_i,
  input  logic [IdW-1:0]           frame_id_i,
  input  logic                     extended_flag_i,
  input  logic signed [EncW-1:0]   encoder_word_i,
  input  logic signed [EncW-1:0]   speed_word_i,
  input  logic signed [EncW-1:0]   current_word_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     bus_out_o,
  output logic [SlotW-1:0]         motor_slot_o,
  output logic signed [EncW-1:0]   signed_encoder_o,
  output logic signed [TurnW-1:0]  turn_count_o,
  output logic signed [FiltW-1:0]  speed_filtered_o,
  output logic signed [FiltW-1:0]  current_filtered_o,
  output logic signed [AngW-1:0]   angle_filtered_o
);

  localparam int unsigned SlotCount  = NUM_BUSES * MOTORS_PER_BUS;
  localparam int unsigned StateDepth = (SlotCount < 16) ? SlotCount : 16;
  localparam int unsigned IdxW       = (StateDepth > 1) ? $clog2(StateDepth) : 1;
  localparam logic [2:0]  NumBusesL  = 3'(NUM_BUSES);
  localparam logic [3:0]  MpbL       = 4'(MOTORS_PER_BUS);
  localparam logic [4:0]  DepthL     = 5'(StateDepth);

  // Q.8 conversion with optional negation; negated -32768 saturates.
  function automatic logic [FiltW-1:0] to_q8(input logic [EncW-1:0] v, input logic neg);
    logic [EncW-1:0] m;
    m = neg ? (EncW'(0) - v) : v;
    if (neg && (v == {1'b1, {(EncW-1){1'b0}}})) begin
      return {1'b0, {(FiltW-1){1'b1}}};
    end
    return {m, 8'h00};
  endfunction

  // Configuration registers
  logic [15:0]       present_q;
  logic [15:0]       reverse_q;
  logic [AlphaW-1:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
      reverse_q <= '0;
      alpha_q   <= AlphaReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegPresent: present_q <= cfg_wdata_i;
        RegReverse: reverse_q <= cfg_wdata_i;
        RegAlpha:   alpha_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Frame decode
  logic [IdW-1:0]     slot_wide;
  logic [SlotW-1:0]   slot;
  logic [4:0]         idx_wide;
  logic [MaxIdxW-1:0] idx;
  logic               id_ok;
  logic               bus_ok;
  logic               slot_ok;
  logic               keep;
  logic               rev;
  logic               hazard;
  logic               space;
  logic               take;
  item_t              item;

  assign slot_wide = frame_id_i - IdFirst;
  assign slot      = slot_wide[SlotW-1:0];
  assign id_ok     = !extended_flag_i && (frame_id_i >= IdFirst) && (frame_id_i <= IdLast);
  assign bus_ok    = {2'b00, bus_index_i} < NumBusesL;
  assign slot_ok   = {1'b0, slot} < MpbL;
  assign idx_wide  = (bus_index_i ? {1'b0, MpbL} : 5'd0) + {2'b00, slot};
  assign idx       = idx_wide[MaxIdxW-1:0];
  assign keep      = id_ok && bus_ok && slot_ok && (idx_wide < DepthL) && present_q[idx];
  assign rev       = reverse_q[idx];

  assign item.bus  = bus_index_i;
  assign item.slot = slot;
  assign item.enc  = rev ? (EncW'(0) - encoder_word_i) : encoder_word_i;
  assign item.xs   = to_q8(speed_word_i, rev);
  assign item.xc   = to_q8(current_word_i, rev);

  pipe_stat_t stat;
  entry_t     rd_ent;
  logic       wr_en;
  logic [MaxIdxW-1:0] wr_idx;
  entry_t     wr_ent;
  result_t    res;
  result_t    out_res;

  // A motor still in flight before write-back must not be read again; the
  // last stage is covered by the memory bypass.
  assign hazard = (stat.a.vld && (stat.a.idx == idx))
               || (stat.b.vld && (stat.b.idx == idx))
               || (stat.c.vld && (stat.c.idx == idx));

  assign in_ready_o = !keep || (!hazard && space);
  assign take       = in_valid_i && in_ready_o && keep;

  mfmd_state_mem #(
    .DEPTH(StateDepth)
  ) u_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (take),
    .rd_idx_i (idx[IdxW-1:0]),
    .rd_ent_o (rd_ent),
    .wr_en_i  (wr_en),
    .wr_idx_i (wr_idx[IdxW-1:0]),
    .wr_ent_i (wr_ent)
  );

  mfmd_pipe #(
    .COUNTS_PER_TURN(COUNTS_PER_TURN)
  ) u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_vld_i  (take),
    .in_idx_i  (idx),
    .in_item_i (item),
    .alpha_i   (alpha_q),
    .ent_i     (rd_ent),
    .stat_o    (stat),
    .wr_en_o   (wr_en),
    .wr_idx_o  (wr_idx),
    .wr_ent_o  (wr_ent),
    .res_o     (res)
  );

  mfmd_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .reserve_i   (take),
    .space_o     (space),
    .push_i      (wr_en),
    .push_data_i (res),
    .out_vld_o   (out_valid_o),
    .out_rdy_i   (out_ready_i),
    .out_data_o  (out_res)
  );

  assign bus_out_o          = out_res.bus;
  assign motor_slot_o       = out_res.slot;
  assign signed_encoder_o   = out_res.enc;
  assign turn_count_o       = out_res.turns;
  assign speed_filtered_o   = out_res.speed;
  assign current_filtered_o = out_res.current;
  assign angle_filtered_o   = out_res.angle;

  `MFMD_ASSERT_IMPL(a_drop_never_stalls, in_valid_i && !keep, in_ready_o, "dropped frame stalled")
  `MFMD_ASSERT_LAT(a_take_to_writeback, take, 4, wr_en, "taken frame missed write-back")
  `MFMD_ASSERT_IMPL(a_no_motor_overlap, stat.a.vld,
    (!stat.b.vld || (stat.a.idx != stat.b.idx))
      && (!stat.c.vld || (stat.a.idx != stat.c.idx))
      && (!stat.d.vld || (stat.a.idx != stat.d.idx)),
    "same motor twice in the update pipeline")

endmodule
